[src/thd_pkg.sv]
// Package for the table Huffman decoder: request, response, table entry
// and control/status types, field widths and status codes.
// No dependencies.
`default_nettype none

package thd_pkg;

   localparam int BYTE_BITS = 8;
   localparam int BIT_CNT_W = $clog2(BYTE_BITS + 1);
   localparam int SYM_W     = 8;
   localparam int CODE_W    = 16;
   localparam int LEN_W     = 5;
   localparam int PAD_W     = 3;
   localparam int LEFT_W    = 5;
   localparam int STAT_W    = 2;

   localparam logic [STAT_W-1:0] ST_SYMBOL   = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERLONG = 2'd1;
   localparam logic [STAT_W-1:0] ST_END      = 2'd2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [SYM_W-1:0]  entry_symbol;
      logic [CODE_W-1:0] entry_code;
      logic [LEN_W-1:0]  entry_length;
      logic [7:0]        data_byte;
      logic              final_byte;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic [STAT_W-1:0] status;
      logic [LEFT_W-1:0] leftover_bits;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic              take_load;
      logic              take_decode;
      logic              scan_start;
      logic              scan_run;
      logic              key_load;
      logic              tbl_write;
      logic              shift_bit;
      logic              res_make;
      logic              res_flush;
      logic [STAT_W-1:0] res_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic bad_len;
      logic full;
      logic overlong;
      logic bits_done;
      logic fin;
      logic out_free;
      logic hold_valid;
   } dp_status_type;

endpackage

`default_nettype wire

[src/thd_controller.sv]
// Control state machine of the table Huffman decoder.
// Sequences loads, bit shifts, table scans and result hand-off; uses thd_pkg.
`default_nettype none

module thd_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_is_decode,
   output logic                       req_ready,
   input  wire thd_pkg::dp_status_type status,
   output thd_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LCHK   = 8'b0000_0010,
      S_LSCAN  = 8'b0000_0100,
      S_SHIFT  = 8'b0000_1000,
      S_SCAN   = 8'b0001_0000,
      S_RESULT = 8'b0010_0000,
      S_NEXT   = 8'b0100_0000,
      S_FLUSH  = 8'b1000_0000
   } state_type;

   state_type                       state_ff, state_in;
   logic [thd_pkg::STAT_W-1:0]      kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_is_decode) begin
                  cmd.take_decode = 1'b1;
                  state_in        = S_SHIFT;
               end else begin
                  cmd.take_load = 1'b1;
                  state_in      = S_LCHK;
               end
            end
         end
         S_LCHK: begin
            if (status.bad_len) begin
               state_in = S_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_LSCAN;
            end
         end
         S_LSCAN: begin
            cmd.key_load = 1'b1;
            if (status.hit) begin
               state_in = S_IDLE;
            end else if (status.miss) begin
               cmd.tbl_write = !status.full;
               state_in      = S_IDLE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_SHIFT: begin
            cmd.shift_bit  = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (status.hit) begin
               kind_in  = thd_pkg::ST_SYMBOL;
               state_in = S_RESULT;
            end else if (status.miss) begin
               if (status.overlong) begin
                  kind_in  = thd_pkg::ST_OVERLONG;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_NEXT;
               end
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_RESULT: begin
            if (!status.hold_valid || status.out_free) begin
               cmd.res_make = 1'b1;
               cmd.res_kind = kind_ff;
               state_in     = (kind_ff == thd_pkg::ST_END) ? S_FLUSH : S_NEXT;
            end
         end
         S_NEXT: begin
            if (status.bits_done) begin
               if (status.fin) begin
                  kind_in  = thd_pkg::ST_END;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_FLUSH;
               end
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_FLUSH: begin
            if (!status.hold_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.res_flush = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= thd_pkg::ST_SYMBOL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

[src/thd_datapath.sv]
// Datapath of the table Huffman decoder: code table memory, scan pointer,
// code accumulator, byte shifter and the result hold and output registers.
// Uses thd_pkg; driven by thd_controller.
`default_nettype none

module thd_datapath #(
   parameter int TABLE_ENTRIES = 256,
   parameter int MAX_CODE_LEN  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire thd_pkg::req_type          req_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [thd_pkg::PAD_W-1:0] csr_wr_data,
   input  wire thd_pkg::ctrl_cmd_type     cmd,
   output thd_pkg::dp_status_type         status,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output thd_pkg::rsp_type               rsp_data
);

   localparam int AW  = $clog2(TABLE_ENTRIES);
   localparam int CW  = $clog2(TABLE_ENTRIES + 1);
   localparam int LW  = $clog2(MAX_CODE_LEN + 1);
   localparam int KW  = (MAX_CODE_LEN > thd_pkg::CODE_W) ? MAX_CODE_LEN : thd_pkg::CODE_W;
   localparam int KLW = (LW > thd_pkg::LEN_W) ? LW : thd_pkg::LEN_W;
   localparam int BCW = thd_pkg::BIT_CNT_W;

   thd_pkg::entry_type             mem [TABLE_ENTRIES];
   thd_pkg::entry_type             rd_ff;
   thd_pkg::entry_type             ent_ff, ent_in;
   logic [thd_pkg::PAD_W-1:0]      pad_ff, pad_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic                           pend_ff, pend_in;
   logic [MAX_CODE_LEN-1:0]        accum_ff, accum_in;
   logic [LW-1:0]                  alen_ff, alen_in;
   logic [thd_pkg::BYTE_BITS-1:0]  byte_ff, byte_in;
   logic                           fin_ff, fin_in;
   logic [BCW-1:0]                 nbits_ff, nbits_in;
   logic [BCW-1:0]                 bitcnt_ff, bitcnt_in;
   logic                           hold_valid_ff, hold_valid_in;
   thd_pkg::rsp_type               hold_ff, hold_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   thd_pkg::rsp_type               rsp_ff, rsp_in;

   logic [thd_pkg::CODE_W-1:0]     masked_code;
   logic [KW-1:0]                  key_code;
   logic [KLW-1:0]                 key_len;
   logic                           more;
   logic                           issue;
   thd_pkg::rsp_type               new_res;

   always_comb begin
      for (int i = 0; i < thd_pkg::CODE_W; i++) begin
         masked_code[i] = req_data.entry_code[i] &
                          (thd_pkg::LEN_W'(i) < req_data.entry_length);
      end
   end

   assign key_code = cmd.key_load ? KW'(ent_ff.code) : KW'(accum_ff);
   assign key_len  = cmd.key_load ? KLW'(ent_ff.length) : KLW'(alen_ff);
   assign more     = idx_ff < count_ff;
   assign issue    = cmd.scan_run && more;

   always_comb begin
      status.hit        = pend_ff && (KW'(rd_ff.code) == key_code) &&
                          (KLW'(rd_ff.length) == key_len);
      status.miss       = !pend_ff && !more;
      status.bad_len    = (ent_ff.length == '0) ||
                          (KLW'(ent_ff.length) > KLW'(MAX_CODE_LEN));
      status.full       = count_ff == CW'(TABLE_ENTRIES);
      status.overlong   = alen_ff == LW'(MAX_CODE_LEN);
      status.bits_done  = bitcnt_ff == nbits_ff;
      status.fin        = fin_ff;
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.hold_valid = hold_valid_ff;
   end

   always_comb begin
      new_res.symbol        = (cmd.res_kind == thd_pkg::ST_SYMBOL) ? rd_ff.symbol : '0;
      new_res.status        = cmd.res_kind;
      new_res.leftover_bits = (cmd.res_kind == thd_pkg::ST_END) ?
                              thd_pkg::LEFT_W'(alen_ff) : '0;
      new_res.last          = 1'b0;
   end

   always_comb begin
      pad_in        = csr_wr_en ? csr_wr_data : pad_ff;
      count_in      = count_ff + CW'(cmd.tbl_write);
      ent_in        = ent_ff;
      accum_in      = accum_ff;
      alen_in       = alen_ff;
      byte_in       = byte_ff;
      fin_in        = fin_ff;
      nbits_in      = nbits_ff;
      bitcnt_in     = bitcnt_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (cmd.take_load) begin
         ent_in.symbol = req_data.entry_symbol;
         ent_in.code   = masked_code;
         ent_in.length = req_data.entry_length;
      end
      if (cmd.take_decode) begin
         byte_in   = req_data.data_byte;
         fin_in    = req_data.final_byte;
         nbits_in  = req_data.final_byte ?
                     (BCW'(thd_pkg::BYTE_BITS) - BCW'(pad_ff)) : BCW'(thd_pkg::BYTE_BITS);
         bitcnt_in = '0;
      end
      if (cmd.shift_bit) begin
         accum_in  = {accum_ff[MAX_CODE_LEN-2:0], byte_ff[thd_pkg::BYTE_BITS-1]};
         alen_in   = alen_ff + LW'(1);
         byte_in   = {byte_ff[thd_pkg::BYTE_BITS-2:0], 1'b0};
         bitcnt_in = bitcnt_ff + BCW'(1);
      end
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in  = idx_ff + CW'(1);
         pend_in = 1'b1;
      end
      if (cmd.res_make) begin
         accum_in = '0;
         alen_in  = '0;
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = hold_ff;
         end
         hold_in       = new_res;
         hold_valid_in = 1'b1;
      end
      if (cmd.res_flush && hold_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = hold_ff;
         rsp_in.last   = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff        <= '0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         accum_ff      <= '0;
         alen_ff       <= '0;
         bitcnt_ff     <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pad_ff        <= pad_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         accum_ff      <= accum_in;
         alen_ff       <= alen_in;
         bitcnt_ff     <= bitcnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      byte_ff  <= byte_in;
      fin_ff   <= fin_in;
      nbits_ff <= nbits_in;
      idx_ff   <= idx_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_write) begin
         mem[count_ff[AW-1:0]] <= ent_ff;
      end
      if (issue) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[src/table_huffman_decoder_unit.sv]
// Top level of the table Huffman decoder with a loadable code table.
// Instantiates thd_controller and thd_datapath; uses thd_pkg.
//
//   Port group   Direction  Handshake          Payload
//   req_*        in         valid / ready      thd_pkg::req_type
//   rsp_*        out        valid / ready      thd_pkg::rsp_type
//   csr_*        in         write enable only  pad_bits, 3 bits
//
// Each table lookup scans the stored entries in order through one registered
// memory read port.
// Reset clears the entry count, the accumulator and pad_bits; the table needs
// no clearing. A stalled response holds the block only when a second result
// must pass the output register.
`default_nettype none

module table_huffman_decoder_unit #(
   parameter int TABLE_ENTRIES = 256,
   parameter int MAX_CODE_LEN  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire thd_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output thd_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [thd_pkg::PAD_W-1:0] csr_wr_data
);

   thd_pkg::ctrl_cmd_type  cmd;
   thd_pkg::dp_status_type status;

   thd_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_is_decode (req_data.cmd == thd_pkg::CMD_DECODE),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   thd_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CODE_LEN  (MAX_CODE_LEN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[src/thd_checker.sv]
// Port-level checker for the table Huffman decoder and its bind statement.
// Uses thd_pkg; attaches to table_huffman_decoder_unit.
`default_nettype none

module thd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire thd_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed or dropped.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == thd_pkg::ST_SYMBOL) ||
                    (rsp_data.status == thd_pkg::ST_OVERLONG) ||
                    (rsp_data.status == thd_pkg::ST_END))
      else $error("Response carries an undefined status.");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == thd_pkg::ST_END) |-> rsp_data.last)
      else $error("End of stream result is not marked last.");

   a_symbol_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != thd_pkg::ST_SYMBOL) |-> rsp_data.symbol == '0)
      else $error("Non-symbol result carries a symbol.");

   a_leftover_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != thd_pkg::ST_END) |-> rsp_data.leftover_bits == '0)
      else $error("Leftover count outside an end of stream result.");

endmodule

bind table_huffman_decoder_unit thd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for table_huffman_decoder_unit: loads code tables, decodes packed byte
// streams and checks every response against a decoder model kept in the bench.
// Depends on thd_pkg and the decoder RTL.

module tb;
   import thd_pkg::*;

   localparam int     TABLE_ENTRIES = 256;
   localparam int     MAX_CODE_LEN  = 16;
   localparam int     SETTLE_CYCLES = 8 * (TABLE_ENTRIES + 5) + 32;
   localparam int     RANDOM_ITEMS  = 280;
   localparam longint TIMEOUT_NS    = 40_000_000;

   class stream_decoder_model;
      logic [SYM_W-1:0]  tbl_sym  [TABLE_ENTRIES];
      logic [CODE_W-1:0] tbl_code [TABLE_ENTRIES];
      int unsigned       tbl_len  [TABLE_ENTRIES];
      int unsigned       stored_count;
      logic [CODE_W-1:0] acc_bits;
      int unsigned       acc_len;
      int unsigned       pad;
      rsp_type           expected_q[$];
      int                errors;

      function new();
         stored_count = 0;
         acc_bits     = '0;
         acc_len      = 0;
         pad          = 0;
         errors       = 0;
      endfunction

      function int find_code(logic [CODE_W-1:0] code, int unsigned len);
         for (int i = 0; i < stored_count; i++) begin
            if (tbl_len[i] == len && tbl_code[i] == code) return i;
         end
         return -1;
      endfunction

      function void note_request(req_type r);
         rsp_type           res_q[$];
         rsp_type           res;
         logic [CODE_W-1:0] code;
         logic [CODE_W:0]   mask;
         int unsigned       len;
         int unsigned       nbits;
         int                hit;
         if (r.cmd == CMD_LOAD) begin
            len = 32'(r.entry_length);
            if (len == 0 || len > MAX_CODE_LEN) return;
            mask = ({{CODE_W{1'b0}}, 1'b1} << len) - 1'b1;
            code = r.entry_code & mask[CODE_W-1:0];
            if (find_code(code, len) >= 0 || stored_count >= TABLE_ENTRIES) return;
            tbl_sym[stored_count]  = r.entry_symbol;
            tbl_code[stored_count] = code;
            tbl_len[stored_count]  = len;
            stored_count++;
            return;
         end
         nbits = r.final_byte ? BYTE_BITS - pad : BYTE_BITS;
         for (int i = 0; i < nbits; i++) begin
            acc_bits = {acc_bits[CODE_W-2:0], r.data_byte[BYTE_BITS-1-i]};
            acc_len++;
            hit = find_code(acc_bits, acc_len);
            res = '0;
            if (hit >= 0) begin
               res.symbol = tbl_sym[hit];
               res.status = ST_SYMBOL;
               res_q.push_back(res);
               acc_bits = '0;
               acc_len  = 0;
            end else if (acc_len >= MAX_CODE_LEN) begin
               res.status = ST_OVERLONG;
               res_q.push_back(res);
               acc_bits = '0;
               acc_len  = 0;
            end
         end
         if (r.final_byte) begin
            res = '0;
            res.status        = ST_END;
            res.leftover_bits = LEFT_W'(acc_len);
            res_q.push_back(res);
            acc_bits = '0;
            acc_len  = 0;
         end
         if (res_q.size() > 0) begin
            res = res_q.pop_back();
            res.last = 1'b1;
            res_q.push_back(res);
         end
         foreach (res_q[k]) expected_q.push_back(res_q[k]);
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response %h arrived with none expected", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.symbol !== want.symbol)
            report($sformatf("symbol %h, expected %h", got.symbol, want.symbol));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.leftover_bits !== want.leftover_bits)
            report($sformatf("leftover_bits %0d, expected %0d",
                             got.leftover_bits, want.leftover_bits));
         if (got.last !== want.last)
            report($sformatf("last %b, expected %b", got.last, want.last));
      endtask
   endclass

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [PAD_W-1:0] csr_wr_data = '0;
   bit               req_idle_on = 1'b1;
   bit               rsp_idle_on = 1'b1;
   int               rsp_stall_left = 0;
   int unsigned      items_sent  = 0;
   stream_decoder_model decoder_model;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   table_huffman_decoder_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(1, 12);
      end
      rsp_ready <= (rsp_stall_left == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) decoder_model.check_response(rsp_data);
   end

   task automatic send_request(req_type r);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      decoder_model.note_request(r);
      items_sent++;
   endtask

   function automatic req_type noise_request();
      req_type r;
      r.cmd          = 1'($urandom_range(0, 1));
      r.entry_symbol = SYM_W'($urandom);
      r.entry_code   = CODE_W'($urandom);
      r.entry_length = LEN_W'($urandom);
      r.data_byte    = BYTE_BITS'($urandom);
      r.final_byte   = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic load_code(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                            int unsigned len);
      req_type r;
      r = noise_request();
      r.cmd          = CMD_LOAD;
      r.entry_symbol = sym;
      r.entry_code   = code;
      r.entry_length = LEN_W'(len);
      send_request(r);
   endtask

   task automatic decode_byte(logic [BYTE_BITS-1:0] data, logic fin);
      req_type r;
      r = noise_request();
      r.cmd        = CMD_DECODE;
      r.data_byte  = data;
      r.final_byte = fin;
      send_request(r);
   endtask

   task automatic random_load();
      int unsigned len;
      case ($urandom_range(0, 9))
         0: begin
            len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_CODE_LEN + 1, 31);
         end
         1, 2: begin
            len = $urandom_range(9, MAX_CODE_LEN);
         end
         default: begin
            len = $urandom_range(1, 8);
         end
      endcase
      load_code(SYM_W'($urandom), CODE_W'($urandom), len);
   endtask

   // A stream of stored codewords, filled up with random bits to where the padding begins.
   // A fault of 1 flips one bit, a fault of 2 drops the final flag.
   task automatic send_stream(int unsigned n_codes, int unsigned fault);
      bit                   stream_bits[$];
      int unsigned          idx;
      int unsigned          pos;
      int unsigned          nbytes;
      logic [BYTE_BITS-1:0] data;
      logic                 fin;
      for (int k = 0; k < n_codes; k++) begin
         idx = $urandom_range(0, decoder_model.stored_count - 1);
         for (int j = decoder_model.tbl_len[idx] - 1; j >= 0; j--) begin
            stream_bits.push_back(decoder_model.tbl_code[idx][j]);
         end
      end
      while (stream_bits.size() + decoder_model.pad < BYTE_BITS ||
             (stream_bits.size() + decoder_model.pad) % BYTE_BITS != 0) begin
         stream_bits.push_back(1'($urandom_range(0, 1)));
      end
      repeat (decoder_model.pad) stream_bits.push_back(1'($urandom_range(0, 1)));
      if (fault == 1) begin
         pos = $urandom_range(0, stream_bits.size() - 1);
         stream_bits[pos] = !stream_bits[pos];
      end
      nbytes = stream_bits.size() / BYTE_BITS;
      for (int b = 0; b < nbytes; b++) begin
         for (int j = 0; j < BYTE_BITS; j++) begin
            data[BYTE_BITS-1-j] = stream_bits[b * BYTE_BITS + j];
         end
         fin = (b == nbytes - 1) && (fault != 2);
         decode_byte(data, fin);
      end
   endtask

   task automatic set_pad(int unsigned value);
      req_valid <= 1'b0;
      while (decoder_model.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= PAD_W'(value);
      decoder_model.pad = value & 7;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned phase;
      int unsigned start_count;
      int unsigned fault;
      decoder_model = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // With an empty table every full-length bit run ends as an overlong code.
      decode_byte(8'h00, 1'b0);
      decode_byte(8'h00, 1'b0);
      decode_byte(8'hFF, 1'b1);
      load_code(8'h5A, 16'h1234, 0);
      load_code(8'h5A, 16'h1234, MAX_CODE_LEN + 1);
      load_code(8'h5A, 16'h1234, 31);
      load_code(8'hA5, 16'hFFFE, 1);
      load_code(8'hFF, 16'h0002, 2);
      load_code(8'h11, 16'h5556, 2);
      load_code(8'h00, 16'hFFFF, MAX_CODE_LEN);
      load_code(8'h3C, 16'h0006, 3);
      decode_byte(8'h00, 1'b1);
      decode_byte(8'h00, 1'b0);
      decode_byte(8'hFF, 1'b0);
      decode_byte(8'hFF, 1'b0);
      decode_byte(8'hB6, 1'b0);
      decode_byte(8'h7F, 1'b0);
      decode_byte(8'hFF, 1'b0);
      decode_byte(8'h7F, 1'b1);
      set_pad(7);
      decode_byte(8'h80, 1'b1);
      decode_byte(8'h00, 1'b1);
      set_pad(3);
      decode_byte(8'hD9, 1'b1);

      phase       = 0;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         req_idle_on = (phase != 2) && (items_sent - start_count < RANDOM_ITEMS * 3 / 4);
         rsp_idle_on = req_idle_on;
         case (phase % 4)
            0: set_pad(7);
            1: set_pad(0);
            default: set_pad($urandom_range(0, 7));
         endcase
         repeat ($urandom_range(2, 5)) random_load();
         repeat ($urandom_range(3, 6)) begin
            fault = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            if (fault == 3) begin
               repeat ($urandom_range(1, 4)) begin
                  decode_byte(BYTE_BITS'($urandom), 1'($urandom_range(0, 1)));
               end
            end else begin
               send_stream($urandom_range(1, 6), fault);
            end
         end
         phase++;
      end

      // Fill the table, then try loads that no longer fit.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      while (decoder_model.stored_count < TABLE_ENTRIES) begin
         load_code(SYM_W'($urandom), CODE_W'($urandom), MAX_CODE_LEN);
      end
      repeat (4) begin
         load_code(SYM_W'($urandom), CODE_W'($urandom), $urandom_range(1, MAX_CODE_LEN));
      end
      set_pad($urandom_range(0, 7));
      send_stream(3, 0);
      send_stream(2, 0);
      decode_byte(BYTE_BITS'($urandom), 1'b1);

      req_valid <= 1'b0;
      while (decoder_model.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (decoder_model.errors == 0 && decoder_model.expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
src/thd_pkg.sv
src/thd_controller.sv
src/thd_datapath.sv
src/table_huffman_decoder_unit.sv
src/thd_checker.sv
tb/tb.sv
